// ----- design/ipt_pkg.sv -----
// Shared types, codes and helper functions for the IPv4 prefix table.
package ipt_pkg;

  // Fixed field widths.
  localparam int ADDR_W = 32;
  localparam int LEN_W = 6;
  localparam int HANDLE_W = 12;
  localparam int MAX_LEN = 32;

  // Default sizing of the hash store.
  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_WAYS = 4;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DIV,
    S_REM,
    S_WAIT,
    S_FINISH
  } state_t;

  // One stored slot.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
  } entry_t;

  // One probe of a bucket: the key and length to compare against.
  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [LEN_W-1:0]  len;
    logic              last;
  } probe_t;

  // Compare outcome for one probed bucket.
  typedef struct packed {
    logic             hit;
    logic             has_free;
    logic             last;
    logic [LEN_W-1:0] len;
  } match_t;

  // Right shift where a count of 32 or more gives zero.
  function automatic logic [ADDR_W-1:0] shr32(input logic [ADDR_W-1:0] v,
                                              input logic [LEN_W:0] n);
    logic [ADDR_W-1:0] r;
    if (n >= (LEN_W+1)'(ADDR_W)) begin
      r = '0;
    end else begin
      r = v >> n[4:0];
    end
    return r;
  endfunction

  // Network mask of the given length; length zero gives an empty mask.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] l);
    logic [ADDR_W-1:0] m;
    if (l == '0) begin
      m = '0;
    end else if (l >= LEN_W'(MAX_LEN)) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> l[4:0]);
    end
    return m;
  endfunction

endpackage

// ----- design/ipt_hash.sv -----
// Pipelined bucket hash: shift-xor of the key, then reduction modulo the bucket count.
module ipt_hash import ipt_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  probe_t                                in_probe,
  output logic                                  out_valid,
  output probe_t                                out_probe,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] out_bucket
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int LOG_B = $clog2(BUCKETS);
  localparam int SHIFT = ADDR_W + LOG_B;
  // Reciprocal of the bucket count, exact for every 32-bit dividend.
  localparam logic [63:0] MUL64 = ((64'd1 << SHIFT) / 64'(BUCKETS)) + 64'd1;
  localparam logic [32:0] MUL = MUL64[32:0];
  localparam logic [15:0] MUL_LO = MUL[15:0];
  localparam logic [16:0] MUL_HI = MUL[32:16];
  localparam logic [16:0] BK = 17'(BUCKETS);

  logic [4:0]        vld;
  probe_t            pr1, pr2, pr3, pr4;
  logic [ADDR_W-1:0] h1, h2, h3, h4;
  logic [47:0]       plo;
  logic [48:0]       phi;
  logic [65:0]       prod;
  logic [31:0]       q3;
  logic [48:0]       qb_full;
  logic [31:0]       qb4;
  logic [31:0]       rem;
  logic [31:0]       rem_fix;

  // Valid bits of the five stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // Stage one: shift-xor hash of the key.
  always_ff @(posedge clk) begin
    pr1 <= in_probe;
    h1 <= shr32(in_probe.key, {1'b0, in_probe.len}) ^
          shr32(in_probe.key, (LEN_W+1)'(in_probe.len) + (LEN_W+1)'(5));
  end

  // Stage two: partial products of the hash and the reciprocal.
  always_ff @(posedge clk) begin
    pr2 <= pr1;
    h2 <= h1;
    plo <= 48'(h1) * 48'(MUL_LO);
    phi <= 49'(h1) * 49'(MUL_HI);
  end

  // Stage three: quotient from the summed product.
  assign prod = {1'b0, phi, 16'd0} + 66'(plo);

  always_ff @(posedge clk) begin
    pr3 <= pr2;
    h3 <= h2;
    q3 <= 32'(prod >> SHIFT);
  end

  // Stage four: quotient times bucket count.
  assign qb_full = 49'(q3) * 49'(BK);

  always_ff @(posedge clk) begin
    pr4 <= pr3;
    h4 <= h3;
    qb4 <= qb_full[31:0];
  end

  // Stage five: remainder with one correction step.
  assign rem = h4 - qb4;
  assign rem_fix = (rem >= 32'(BK)) ? rem - 32'(BK) : rem;

  always_ff @(posedge clk) begin
    out_probe <= pr4;
    out_bucket <= BKT_W'(rem_fix);
  end

  assign out_valid = vld[4];

endmodule

// ----- design/ipt_mem.sv -----
// Bucket memory: one row of ways per bucket, one write and one registered read a cycle.
module ipt_mem import ipt_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic                                          clk,
  input  logic                                          rd_en,
  input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] rd_addr,
  output entry_t [WAYS-1:0]                             rd_row,
  input  logic                                          wr_en,
  input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] wr_addr,
  input  entry_t [WAYS-1:0]                             wr_row
);

  entry_t [WAYS-1:0] rows [BUCKETS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr] <= wr_row;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= rows[rd_addr];
    end
  end

endmodule

// ----- design/ipt_match.sv -----
// Compare stage: checks a bucket row against a probe and finds the first hit and free way.
module ipt_match import ipt_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          req_valid,
  input  probe_t                                        req_probe,
  input  logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] req_bucket,
  input  entry_t [WAYS-1:0]                             rd_row,
  output logic                                          res_valid,
  output match_t                                        res,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]      res_hit_way,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]      res_free_way,
  output entry_t [WAYS-1:0]                             res_row,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] res_bucket
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic             a_valid;
  probe_t           a_probe;
  logic [BKT_W-1:0] a_bucket;
  logic             hit;
  logic             has_free;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  // Hold the probe while the memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_probe <= req_probe;
    a_bucket <= req_bucket;
  end

  // Lowest matching way and lowest free way.
  always_comb begin
    hit = 1'b0;
    has_free = 1'b0;
    hit_way = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && rd_row[w].prefix == a_probe.key &&
          rd_row[w].length == a_probe.len) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_row[w].valid) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    res.hit <= hit;
    res.has_free <= has_free;
    res.last <= a_probe.last;
    res.len <= a_probe.len;
    res_hit_way <= hit_way;
    res_free_way <= free_way;
    res_row <= rd_row;
    res_bucket <= a_bucket;
  end

endmodule

// ----- design/ipv4_prefix_table_lpm.sv -----
// Top level of the IPv4 prefix table with exact get and longest prefix match.
//
// The input stream carries one command word: mode in s_axis_tuser, and
// address, prefix length and handle in s_axis_tdata. Each command gives
// exactly one result word on the output stream: status, handle and length.
// Entries live in a bucket memory, one row of ways per bucket; a command
// hashes its key, reads the bucket row, compares all ways in parallel and,
// for add and remove, writes the modified row back.
// Commands are handled one at a time. A lookup probes lengths 32 down to 0,
// one per cycle into a five-stage hash pipeline, and finishes once the last
// probe returns. Get and add send a single probe, remove reads the bucket
// row named by its handle without the hash, and a length above 32 on add or
// get goes straight to the result.
// After reset a clearing pass writes every bucket row empty, one row a
// cycle; s_axis_tready stays low during it.
// The result sits in an output register; a new command is accepted while it
// waits, and if the receiver stalls, the next result waits inside the block
// until the output register frees up.
module ipv4_prefix_table_lpm import ipt_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int WAYS = DEF_WAYS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // address[31:0], prefix_len[37:32], handle_in[49:38]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status[2:0], handle_out[14:3], matched_len[20:15]
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = BUCKETS * WAYS;
  // Reciprocal of the way count for splitting a handle into bucket and way.
  localparam int LOG_W = $clog2(WAYS);
  localparam int HSHIFT = HANDLE_W + LOG_W;
  localparam logic [12:0] HMUL = 13'(((1 << HSHIFT) / WAYS) + 1);

  state_t              state, state_next;
  mode_t               mode_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [LEN_W-1:0]    len_r;
  logic [HANDLE_W-1:0] hin_r;
  logic [LEN_W-1:0]    iss_len;
  logic                found;
  status_t             pend_status;
  logic [HANDLE_W-1:0] pend_handle;
  logic [LEN_W-1:0]    pend_len;
  logic [HANDLE_W-1:0] rm_q;
  logic [WAY_W-1:0]    rm_way;
  logic [BKT_W-1:0]    clr_addr;
  logic [24:0]         rm_prod;

  logic                in_accept;
  mode_t               in_mode;
  logic [LEN_W-1:0]    in_len;
  logic [HANDLE_W-1:0] in_handle;
  logic                iss_valid;
  probe_t              iss_probe;
  logic                rm_issue;
  logic                load_out;

  logic                hash_valid;
  probe_t              hash_probe;
  logic [BKT_W-1:0]    hash_bucket;

  logic                rd_en;
  logic [BKT_W-1:0]    rd_addr;
  probe_t              rd_probe;
  entry_t [WAYS-1:0]   rd_row;
  logic                wr_en;
  logic [BKT_W-1:0]    wr_addr;
  entry_t [WAYS-1:0]   wr_row;

  logic                res_valid;
  match_t              res;
  logic [WAY_W-1:0]    res_hit_way;
  logic [WAY_W-1:0]    res_free_way;
  entry_t [WAYS-1:0]   res_row;
  logic [BKT_W-1:0]    res_bucket;

  // Slot handle of a bucket and way.
  function automatic logic [HANDLE_W-1:0] handle_of(input logic [BKT_W-1:0] b,
                                                    input logic [WAY_W-1:0] w);
    logic [20:0] full;
    full = 21'(b) * 21'(WAYS) + 21'(w);
    return full[HANDLE_W-1:0];
  endfunction

  assign in_mode = mode_t'(s_axis_tuser);
  assign in_len = s_axis_tdata[37:32];
  assign in_handle = s_axis_tdata[49:38];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Probe for the current length; lookups mask the address to it.
  always_comb begin
    iss_probe.key = (mode_r == MODE_LOOKUP) ? (addr_r & len_mask(iss_len)) : addr_r;
    iss_probe.len = iss_len;
    iss_probe.last = (mode_r != MODE_LOOKUP) || (iss_len == '0);
  end

  ipt_hash #(
    .BUCKETS(BUCKETS)
  ) u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iss_valid),
    .in_probe  (iss_probe),
    .out_valid (hash_valid),
    .out_probe (hash_probe),
    .out_bucket(hash_bucket)
  );

  // Memory reads come from the hash pipeline or from a remove.
  assign rd_en = hash_valid || rm_issue;
  assign rd_addr = hash_valid ? hash_bucket : BKT_W'(rm_q);

  always_comb begin
    if (hash_valid) begin
      rd_probe = hash_probe;
    end else begin
      rd_probe.key = '0;
      rd_probe.len = '0;
      rd_probe.last = 1'b1;
    end
  end

  ipt_mem #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_row (rd_row),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_row (wr_row)
  );

  ipt_match #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (rd_en),
    .req_probe   (rd_probe),
    .req_bucket  (rd_addr),
    .rd_row      (rd_row),
    .res_valid   (res_valid),
    .res         (res),
    .res_hit_way (res_hit_way),
    .res_free_way(res_free_way),
    .res_row     (res_row),
    .res_bucket  (res_bucket)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake, probe issue, output load and memory write strobes.
  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    iss_valid = 1'b0;
    rm_issue = 1'b0;
    load_out = 1'b0;
    wr_en = 1'b0;
    wr_addr = res_bucket;
    wr_row = res_row;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_addr;
        wr_row = '0;
        if (clr_addr == BKT_W'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_mode == MODE_REMOVE) begin
            state_next = (32'(in_handle) >= 32'(SLOTS)) ? S_FINISH : S_DIV;
          end else if (in_mode != MODE_LOOKUP && in_len > LEN_W'(MAX_LEN)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        iss_valid = 1'b1;
        if (iss_probe.last) begin
          state_next = S_WAIT;
        end
      end
      S_DIV: begin
        state_next = S_REM;
      end
      S_REM: begin
        rm_issue = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (res_valid) begin
          if (mode_r == MODE_ADD && !res.hit && res.has_free) begin
            wr_en = 1'b1;
            wr_row[res_free_way] = '{valid: 1'b1, prefix: addr_r, length: len_r};
          end else if (mode_r == MODE_REMOVE && res_row[rm_way].valid) begin
            wr_en = 1'b1;
            wr_row[rm_way].valid = 1'b0;
          end
          if (res.last) begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + BKT_W'(1);
    end
  end

  // Handle split for remove: quotient by reciprocal, then the way.
  assign rm_prod = 25'(hin_r) * 25'(HMUL);

  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      rm_q <= HANDLE_W'(rm_prod >> HSHIFT);
    end
    if (state == S_REM) begin
      rm_way <= WAY_W'(hin_r - HANDLE_W'(21'(rm_q) * 21'(WAYS)));
    end
  end

  // Command fields, issue length and the pending result.
  // Lookup results start to return while later lengths are still being issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (in_accept) begin
      found <= 1'b0;
    end else if ((state == S_PROBE || state == S_WAIT) && res_valid && res.hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_mode;
      addr_r <= s_axis_tdata[31:0];
      len_r <= in_len;
      hin_r <= in_handle;
      iss_len <= (in_mode == MODE_LOOKUP) ? LEN_W'(MAX_LEN) : in_len;
      if (in_mode == MODE_REMOVE) begin
        pend_status <= ST_EMPTY;
        pend_handle <= in_handle;
      end else begin
        pend_status <= ST_NOTFOUND;
        pend_handle <= '0;
      end
      pend_len <= '0;
    end else begin
      if (iss_valid) begin
        iss_len <= iss_len - LEN_W'(1);
      end
      if ((state == S_PROBE || state == S_WAIT) && res_valid) begin
        case (mode_r)
          MODE_LOOKUP, MODE_GET: begin
            if (res.hit && !found) begin
              pend_status <= ST_OK;
              pend_handle <= handle_of(res_bucket, res_hit_way);
              pend_len <= res.len;
            end
          end
          MODE_ADD: begin
            if (res.hit) begin
              pend_status <= ST_DUP;
              pend_handle <= handle_of(res_bucket, res_hit_way);
              pend_len <= len_r;
            end else if (res.has_free) begin
              pend_status <= ST_OK;
              pend_handle <= handle_of(res_bucket, res_free_way);
              pend_len <= len_r;
            end else begin
              pend_status <= ST_FULL;
            end
          end
          MODE_REMOVE: begin
            if (res_row[rm_way].valid) begin
              pend_status <= ST_OK;
              pend_len <= res_row[rm_way].length;
            end
          end
          default: begin
            pend_status <= ST_NOTFOUND;
          end
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {3'd0, pend_len, pend_handle, pend_status};
    end
  end

`ifndef ASSERT_OFF
  // The bucket memory is never written while a probe leaves the hash pipeline.
  a_no_write_during_probe: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !hash_valid)
    else $error("bucket write overlaps a probe read");

  // Compare results arrive only while probes are issued or awaited.
  a_result_in_wait: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_PROBE || state == S_WAIT))
    else $error("compare result outside the probe and wait states");

  // Leaving reset always starts the clearing pass.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> state == S_CLEAR)
    else $error("clearing pass skipped after reset");

  // A finished result with a free output register is shown on the next cycle.
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("finished result not loaded into the output register");
`endif

endmodule
